// ===== sv/hsc_pkg.sv =====
`timescale 1ns / 1ps

package hsc_pkg;

   // Field widths fixed by the interface.
   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = 12;

   // Statistics constants: counts stop at the top of their range.
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = 12'd4095;
   localparam logic [COUNT_WIDTH-1:0] SWAP_MOVES = 12'd3;

   // One element of a set on the request channel.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last_item;
   } req_type;

   // One sorted element with the set totals on the response channel.
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] sorted_value;
      logic                         last_result;
      logic [COUNT_WIDTH-1:0]       move_count;
      logic [COUNT_WIDTH-1:0]       compare_count;
      logic                         overflow;
   } rsp_type;

endpackage

// ===== sv/hsc_ram.sv =====
`timescale 1ns / 1ps

module hsc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/heap_sort_counted.sv =====
`timescale 1ns / 1ps
// Loading takes one element a cycle while req_valid is high; the sort then builds the heap
// bottom up and extracts the top into the end of the shrinking heap, each step sifting a node down.
// Each result is held until rsp_ready takes it; the single read port of the element memory
// serves every step in turn, and no new set is taken until the last result goes.
// Reset is synchronous and active high; it clears the sequencer, counts and output valid.
// The element memory is not cleared: an element is always written before it is read.
module heap_sort_counted #(
   parameter int MAX_ITEMS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hsc_pkg::rsp_type rsp_data
);

   localparam int DW = hsc_pkg::DATA_WIDTH;
   localparam int KW = hsc_pkg::COUNT_WIDTH;
   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int NW = CW + 1;

   // Sequencer states.
   localparam logic [3:0] ST_LOAD    = 4'd0;
   localparam logic [3:0] ST_RD_NODE = 4'd1;
   localparam logic [3:0] ST_NODE    = 4'd2;
   localparam logic [3:0] ST_LEFT    = 4'd3;
   localparam logic [3:0] ST_RIGHT   = 4'd4;
   localparam logic [3:0] ST_CMP     = 4'd5;
   localparam logic [3:0] ST_DONE    = 4'd6;
   localparam logic [3:0] ST_X_TOP   = 4'd7;
   localparam logic [3:0] ST_X_LAST  = 4'd8;
   localparam logic [3:0] ST_X_SWAP  = 4'd9;
   localparam logic [3:0] ST_E_RD    = 4'd10;
   localparam logic [3:0] ST_E_LOAD  = 4'd11;
   localparam logic [3:0] ST_E_WAIT  = 4'd12;

   logic [3:0]           state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        n_ff, n_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [NW-1:0]        i_ff, i_in;
   logic [NW-1:0]        node_ff, node_in;
   logic [NW-1:0]        child_ff, child_in;
   logic [NW-1:0]        last_ff, last_in;
   logic [NW-1:0]        bigidx_ff, bigidx_in;
   logic signed [DW-1:0] nodeval_ff, nodeval_in;
   logic signed [DW-1:0] lval_ff, lval_in;
   logic signed [DW-1:0] bigval_ff, bigval_in;
   logic [KW-1:0]        moves_ff, moves_in;
   logic [KW-1:0]        compares_ff, compares_in;
   logic                 ovf_ff, ovf_in;
   logic                 build_ff, build_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   hsc_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [DW-1:0] ram_wr_data;
   logic [AW-1:0] ram_rd_addr;
   logic [DW-1:0] ram_rd_data;

   logic signed [DW-1:0] rd_value;
   logic                 req_take;
   logic                 item_fits;
   logic [CW-1:0]        n_new;
   logic [NW-1:0]        node_m1;
   logic [NW-1:0]        left_m1;
   logic [NW-1:0]        child_p1;
   logic [NW-1:0]        i_m1;
   logic [NW-1:0]        big_child;
   logic [NW-1:0]        big_child_m1;
   logic [CW-1:0]        k_p1;
   logic [KW:0]          moves_sum;
   logic [KW:0]          compares_sum;
   logic [KW-1:0]        moves_sat;
   logic [KW-1:0]        compares_sat;

   hsc_ram #(
      .WIDTH(DW),
      .DEPTH(MAX_ITEMS)
   ) u_heap_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Index arithmetic and saturating counters.
   always_comb begin
      rd_value     = $signed(ram_rd_data);
      req_take     = req_valid && (state_ff == ST_LOAD);
      item_fits    = (count_ff < CW'(MAX_ITEMS));
      n_new        = item_fits ? (count_ff + CW'(1)) : count_ff;
      node_m1      = node_ff - NW'(1);
      left_m1      = (node_ff << 1) - NW'(1);
      child_p1     = child_ff + NW'(1);
      i_m1         = i_ff - NW'(1);
      big_child    = bigidx_ff << 1;
      big_child_m1 = big_child - NW'(1);
      k_p1         = k_ff + CW'(1);
      moves_sum    = {1'b0, moves_ff} + {1'b0, hsc_pkg::SWAP_MOVES};
      compares_sum = {1'b0, compares_ff} + (KW+1)'(1);
      moves_sat    = (moves_sum > {1'b0, hsc_pkg::COUNT_MAX}) ?
                     hsc_pkg::COUNT_MAX : moves_sum[KW-1:0];
      compares_sat = (compares_sum > {1'b0, hsc_pkg::COUNT_MAX}) ?
                     hsc_pkg::COUNT_MAX : compares_sum[KW-1:0];
   end

   // Sequencer: load, heap build, extraction and result emission.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      node_in      = node_ff;
      child_in     = child_ff;
      last_in      = last_ff;
      bigidx_in    = bigidx_ff;
      nodeval_in   = nodeval_ff;
      lval_in      = lval_ff;
      bigval_in    = bigval_ff;
      moves_in     = moves_ff;
      compares_in  = compares_ff;
      ovf_in       = ovf_ff;
      build_in     = build_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = node_m1[AW-1:0];
      ram_wr_data  = nodeval_ff;
      ram_rd_addr  = node_m1[AW-1:0];

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               // Store the element, or drop it when the memory is full.
               if (item_fits) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = count_ff[AW-1:0];
                  ram_wr_data = req_data.value;
                  count_in    = n_new;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_data.last_item) begin
                  n_in = n_new;
                  k_in = '0;
                  if (n_new == CW'(1)) begin
                     state_in = ST_E_RD;
                  end else begin
                     build_in = 1'b1;
                     i_in     = NW'(n_new) >> 1;
                     node_in  = NW'(n_new) >> 1;
                     last_in  = NW'(n_new);
                     state_in = ST_RD_NODE;
                  end
               end
            end
         end
         ST_RD_NODE: begin
            ram_rd_addr = node_m1[AW-1:0];
            state_in    = ST_NODE;
         end
         ST_NODE: begin
            nodeval_in  = rd_value;
            child_in    = node_ff << 1;
            ram_rd_addr = left_m1[AW-1:0];
            if ((node_ff << 1) > last_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LEFT;
            end
         end
         ST_LEFT: begin
            lval_in = rd_value;
            if (child_ff < last_ff) begin
               ram_rd_addr = child_ff[AW-1:0];
               state_in    = ST_RIGHT;
            end else begin
               bigval_in = rd_value;
               bigidx_in = child_ff;
               state_in  = ST_CMP;
            end
         end
         ST_RIGHT: begin
            // The right child wins only when strictly larger.
            if (lval_ff < rd_value) begin
               bigval_in = rd_value;
               bigidx_in = child_p1;
            end else begin
               bigval_in = lval_ff;
               bigidx_in = child_ff;
            end
            state_in = ST_CMP;
         end
         ST_CMP: begin
            compares_in = compares_sat;
            if (nodeval_ff >= bigval_ff) begin
               state_in = ST_DONE;
            end else begin
               // Move the larger child up; the sifted value follows later.
               ram_wr_en   = 1'b1;
               ram_wr_addr = node_m1[AW-1:0];
               ram_wr_data = bigval_ff;
               moves_in    = moves_sat;
               node_in     = bigidx_ff;
               child_in    = big_child;
               ram_rd_addr = big_child_m1[AW-1:0];
               if (big_child > last_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LEFT;
               end
            end
         end
         ST_DONE: begin
            // Drop the sifted value into its final slot.
            ram_wr_en   = 1'b1;
            ram_wr_addr = node_m1[AW-1:0];
            ram_wr_data = nodeval_ff;
            if (build_ff) begin
               if (i_ff == NW'(1)) begin
                  build_in = 1'b0;
                  i_in     = NW'(n_ff);
                  state_in = ST_X_TOP;
               end else begin
                  i_in     = i_m1;
                  node_in  = i_m1;
                  state_in = ST_RD_NODE;
               end
            end else begin
               if (i_ff == NW'(2)) begin
                  k_in     = '0;
                  state_in = ST_E_RD;
               end else begin
                  i_in     = i_m1;
                  state_in = ST_X_TOP;
               end
            end
         end
         ST_X_TOP: begin
            ram_rd_addr = '0;
            state_in    = ST_X_LAST;
         end
         ST_X_LAST: begin
            lval_in     = rd_value;
            ram_rd_addr = i_m1[AW-1:0];
            state_in    = ST_X_SWAP;
         end
         ST_X_SWAP: begin
            // The top goes to the end; the last entry is sifted from the root.
            ram_wr_en   = 1'b1;
            ram_wr_addr = i_m1[AW-1:0];
            ram_wr_data = lval_ff;
            moves_in    = moves_sat;
            nodeval_in  = rd_value;
            node_in     = NW'(1);
            child_in    = NW'(2);
            last_in     = i_m1;
            ram_rd_addr = AW'(1);
            if (i_ff == NW'(2)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_LEFT;
            end
         end
         ST_E_RD: begin
            ram_rd_addr = k_ff[AW-1:0];
            state_in    = ST_E_LOAD;
         end
         ST_E_LOAD: begin
            rsp_data_in.sorted_value  = rd_value;
            rsp_data_in.last_result   = (k_p1 == n_ff);
            rsp_data_in.move_count    = moves_ff;
            rsp_data_in.compare_count = compares_ff;
            rsp_data_in.overflow      = ovf_ff;
            rsp_valid_in              = 1'b1;
            state_in                  = ST_E_WAIT;
         end
         ST_E_WAIT: begin
            ram_rd_addr = k_p1[AW-1:0];
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_data_ff.last_result) begin
                  // Set finished: start the next one from zero.
                  count_in    = '0;
                  moves_in    = '0;
                  compares_in = '0;
                  ovf_in      = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  k_in     = k_p1;
                  state_in = ST_E_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         moves_ff     <= '0;
         compares_ff  <= '0;
         ovf_ff       <= 1'b0;
         build_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         moves_ff     <= moves_in;
         compares_ff  <= compares_in;
         ovf_ff       <= ovf_in;
         build_ff     <= build_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers and the response payload.
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      k_ff        <= k_in;
      i_ff        <= i_in;
      node_ff     <= node_in;
      child_ff    <= child_in;
      last_ff     <= last_in;
      bigidx_ff   <= bigidx_in;
      nodeval_ff  <= nodeval_in;
      lval_ff     <= lval_in;
      bigval_ff   <= bigval_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // Loading and result emission never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response channels active together");

   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("fill count beyond capacity");

   // The final result of a set hands control back to loading.
   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last_result) |=> req_ready)
      else $error("block not ready after final result");

   // The element memory is never written while results go out.
   a_no_write_emit: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> !(state_ff == ST_E_RD || state_ff == ST_E_LOAD ||
                      state_ff == ST_E_WAIT))
      else $error("memory written during emission");
`endif

endmodule

// ===== sim/heap_sort_counted_checker.sv =====
`timescale 1ns / 1ps

module heap_sort_counted_checker #(
   parameter int MAX_ITEMS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  hsc_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  hsc_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               results_pending
);

   // Shadow copy of the set being collected and its running totals.
   logic signed [hsc_pkg::DATA_WIDTH-1:0] set_elems [MAX_ITEMS];
   int                                    set_size;
   logic [hsc_pkg::COUNT_WIDTH-1:0]       set_moves;
   logic [hsc_pkg::COUNT_WIDTH-1:0]       set_compares;
   logic                                  set_dropped;

   // Sorted elements still owed by the block, oldest first.
   hsc_pkg::rsp_type sorted_q [$];

   // Counts stop at the top of their range.
   function automatic logic [hsc_pkg::COUNT_WIDTH-1:0] saturate_add(
      input logic [hsc_pkg::COUNT_WIDTH-1:0] acc, input int step);
      int sum;
      sum = int'(acc) + step;
      return (sum > int'(hsc_pkg::COUNT_MAX)) ? hsc_pkg::COUNT_MAX :
                                                sum[hsc_pkg::COUNT_WIDTH-1:0];
   endfunction

   // Nodes are numbered from one, as in the heap layout.
   task automatic swap_nodes(input int a, input int b);
      logic signed [hsc_pkg::DATA_WIDTH-1:0] held;
      held            = set_elems[a-1];
      set_elems[a-1]  = set_elems[b-1];
      set_elems[b-1]  = held;
      set_moves       = saturate_add(set_moves, int'(hsc_pkg::SWAP_MOVES));
   endtask

   // Push one node down until it is no smaller than its larger child.
   task automatic sift_down(input int top, input int last);
      int node;
      int child;
      bit settled;
      node    = top;
      child   = 2 * node;
      settled = 1'b0;
      while (!settled && child <= last) begin
         if (child < last && set_elems[child-1] < set_elems[child]) begin
            child++;
         end
         set_compares = saturate_add(set_compares, 1);
         if (set_elems[node-1] >= set_elems[child-1]) begin
            settled = 1'b1;
         end else begin
            swap_nodes(node, child);
            node  = child;
            child = 2 * node;
         end
      end
   endtask

   // Build the max-heap, then move the top to the end of the shrinking heap.
   task automatic heapsort_set(input int count);
      for (int i = count / 2; i >= 1; i--) begin
         sift_down(i, count);
      end
      for (int i = count; i > 1; i--) begin
         swap_nodes(1, i);
         sift_down(1, i - 1);
      end
   endtask

   // Store or drop one element; the last one of a set yields the sorted results.
   task automatic absorb_element(input hsc_pkg::req_type item);
      hsc_pkg::rsp_type entry;
      if (set_size < MAX_ITEMS) begin
         set_elems[set_size] = item.value;
         set_size++;
      end else begin
         set_dropped = 1'b1;
      end
      if (item.last_item) begin
         heapsort_set(set_size);
         for (int k = 0; k < set_size; k++) begin
            entry.sorted_value  = set_elems[k];
            entry.last_result   = (k == set_size - 1);
            entry.move_count    = set_moves;
            entry.compare_count = set_compares;
            entry.overflow      = set_dropped;
            sorted_q.push_back(entry);
         end
         set_size     = 0;
         set_moves    = '0;
         set_compares = '0;
         set_dropped  = 1'b0;
      end
   endtask

   // Every mismatch prints one line and is counted.
   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Watch both channels and compare each result transaction with the oldest expectation.
   always @(posedge clock) begin
      hsc_pkg::rsp_type want;
      if (reset) begin
         set_size       = 0;
         set_moves      = '0;
         set_compares   = '0;
         set_dropped    = 1'b0;
         mismatch_count = 0;
         sorted_q.delete();
      end else begin
         if (req_valid && req_ready) begin
            absorb_element(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (sorted_q.size() == 0) begin
               report_mismatch("unexpected result", rsp_data.sorted_value, 0);
            end else begin
               want = sorted_q.pop_front();
               if (rsp_data.sorted_value !== want.sorted_value) begin
                  report_mismatch("sorted_value", rsp_data.sorted_value, want.sorted_value);
               end
               if (rsp_data.last_result !== want.last_result) begin
                  report_mismatch("last_result", rsp_data.last_result, want.last_result);
               end
               if (rsp_data.move_count !== want.move_count) begin
                  report_mismatch("move_count", rsp_data.move_count, want.move_count);
               end
               if (rsp_data.compare_count !== want.compare_count) begin
                  report_mismatch("compare_count", rsp_data.compare_count,
                                  want.compare_count);
               end
               if (rsp_data.overflow !== want.overflow) begin
                  report_mismatch("overflow", rsp_data.overflow, want.overflow);
               end
            end
         end
      end
      results_pending <= sorted_q.size();
   end

endmodule

// ===== sim/heap_sort_counted_test.sv =====
`timescale 1ns / 1ps

module heap_sort_counted_test;

   localparam int MAX_ITEMS       = 64;
   localparam int RANDOM_ITEMS    = 205;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int DRAIN_CYCLES    = 300;
   localparam int DIRECTED_ITEMS  = 23;
   localparam int DW              = hsc_pkg::DATA_WIDTH;

   // Random sets that get special treatment.
   localparam int HOLD_OFF_SET    = 2;
   localparam int FULL_SET        = 5;
   localparam int PAUSE_SET       = 9;
   localparam int OVERFLOW_SET    = 12;

   localparam logic signed [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_type;
   typedef enum {VALUES_WIDE, VALUES_NARROW, VALUES_CORNER} value_mode_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   hsc_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   hsc_pkg::rsp_type rsp_data;

   int mismatch_count;
   int results_pending;
   int cycle_count      = 0;
   int send_idle_pct    = 0;
   int rsp_stall_pct    = 0;
   bit hold_off_request = 1'b0;

   // Directed sets: single element, both orders of the extremes, equal values,
   // a mix around zero, and a strictly descending set.
   logic signed [DW-1:0] directed_values [DIRECTED_ITEMS] = '{
      WORD_MAX,
      WORD_MIN, WORD_MAX,
      WORD_MAX, WORD_MIN,
      5, 5, 5,
      0, -1, 1, WORD_MIN, WORD_MAX, -2, 2,
      3, 2, 1, 0, -1, -2, -3, -4
   };
   bit directed_last [DIRECTED_ITEMS] = '{
      1,
      0, 1,
      0, 1,
      0, 0, 1,
      0, 0, 0, 0, 0, 0, 1,
      0, 0, 0, 0, 0, 0, 0, 1
   };

   heap_sort_counted #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   heap_sort_counted_checker #(
      .MAX_ITEMS(MAX_ITEMS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .results_pending(results_pending)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Idling rates cycle through four phases, one per set.
   function automatic void apply_idle_phase(input int set_index);
      case (idle_phase_type'(set_index % 4))
         IDLE_NONE: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 86;
            rsp_stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            rsp_stall_pct = 86;
         end
         default: begin
            send_idle_pct = 19;
            rsp_stall_pct = 19;
         end
      endcase
   endfunction

   function automatic logic signed [DW-1:0] pick_value(input value_mode_type mode);
      case (mode)
         VALUES_NARROW: return $urandom_range(8) - 4;
         VALUES_CORNER: begin
            case ($urandom_range(5))
               0:       return WORD_MIN;
               1:       return WORD_MAX;
               2:       return -1;
               3:       return 0;
               4:       return 1;
               default: return $urandom;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Offer one element and hold it until the transaction is accepted.
   task automatic send_item(input logic signed [DW-1:0] value, input bit last);
      hsc_pkg::req_type item;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      item.value     = value;
      item.last_item = last;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Stop sending until every expected result has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // Stimulus and verdict.
   initial begin
      int             set_index;
      int             rand_set;
      int             sent;
      int             set_len;
      value_mode_type mode;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed sets.
      set_index = 0;
      apply_idle_phase(set_index);
      for (int i = 0; i < DIRECTED_ITEMS; i++) begin
         send_item(directed_values[i], directed_last[i]);
         if (directed_last[i]) begin
            set_index++;
            apply_idle_phase(set_index);
         end
      end
      wait_until_drained();

      // Random sets: mostly small, one full, one past capacity.
      sent     = 0;
      rand_set = 0;
      while (sent < RANDOM_ITEMS) begin
         if (rand_set == FULL_SET) begin
            set_len = MAX_ITEMS;
         end else if (rand_set == OVERFLOW_SET) begin
            set_len = MAX_ITEMS + 2;
         end else begin
            set_len = $urandom_range(8, 1);
         end
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: mode = VALUES_WIDE;
            6, 7:             mode = VALUES_NARROW;
            default:          mode = VALUES_CORNER;
         endcase
         if (rand_set == PAUSE_SET) begin
            wait_until_drained();
         end
         if (rand_set == HOLD_OFF_SET) begin
            hold_off_request = 1'b1;
         end
         for (int k = 0; k < set_len; k++) begin
            send_item(pick_value(mode), k == set_len - 1);
         end
         sent += set_len;
         rand_set++;
         set_index++;
         apply_idle_phase(set_index);
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
